/* design/matrix_inverse_cofactor_assert.svh */
// Assertion macros for the matrix inverse block.
// Depends on nothing; the including module supplies clk and rst_n.
`ifndef MATRIX_INVERSE_COFACTOR_ASSERT_SVH
`define MATRIX_INVERSE_COFACTOR_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication under reset.
`define MIC_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("matrix inverse: same-cycle check failed");
// Next-cycle implication under reset.
`define MIC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("matrix inverse: next-cycle check failed");
`else
`define MIC_ASSERT_IMPLY(lbl, ante, cons)
`define MIC_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* design/mic_pkg.sv */
// Shared constants, types and the Q16.16 saturation function of the matrix inverse block.
// Used by mic_divider and matrix_inverse_cofactor; depends on nothing.
package mic_pkg;

    localparam int MAX_ORDER_DEF = 4;
    localparam int ORDER_W       = 3;
    localparam logic [ORDER_W-1:0] ORDER_RESET = 3'd4;
    localparam int LIMB_W        = 32;
    localparam int FRAC_W        = 16;
    localparam int SUM_GUARD     = 11;
    localparam int QUOT_BITS     = 33;

    // Request from the sequencer to the divider.
    typedef struct packed {
        logic go;
        logic neg;
    } div_ctl_t;

    // Saturate a sign and magnitude to a signed 32-bit word.
    function automatic logic [31:0] sat_q32(input logic big, input logic [31:0] mag,
                                            input logic neg);
        logic [31:0] res;
        if (!neg)
        begin
            res = (big || mag[31]) ? 32'h7FFF_FFFF : mag;
        end
        else
        begin
            res = (big || (mag > 32'h8000_0000)) ? 32'h8000_0000 : (~mag) + 32'd1;
        end
        return res;
    endfunction

endpackage

/* design/mic_divider.sv */
// Restoring divider: round(num * 2^32 / den), ties away from zero, saturated to Q16.16.
// Depends on mic_pkg.
module mic_divider #(
    parameter int MAG_W = 139
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  mic_pkg::div_ctl_t      ctl,
    input  logic [MAG_W-1:0]       num_mag,
    input  logic [MAG_W-1:0]       den_mag,
    output logic                   done,
    output logic [31:0]            quot
);

    localparam int DW    = MAG_W + mic_pkg::LIMB_W + 2;
    localparam int CNT_W = $clog2(mic_pkg::QUOT_BITS);
    localparam logic [1:0] DV_IDLE  = 2'd0;
    localparam logic [1:0] DV_RUN   = 2'd1;
    localparam logic [1:0] DV_ROUND = 2'd2;

    logic [1:0]                      st_reg, st_next;
    logic [CNT_W-1:0]                cnt_reg;
    logic                            done_reg;
    logic [DW-1:0]                   rem_reg, dsh_reg;
    logic [mic_pkg::QUOT_BITS-1:0]   q_reg;
    logic                            sat_reg, neg_reg;
    logic [31:0]                     quot_reg;

    logic [DW-1:0]                   num_ext, den_ext, den_sh32, den_sh33, rem_sub;
    logic                            rem_ge, round_up, big;
    logic [mic_pkg::QUOT_BITS:0]     q_round;

    // Operand alignment and one compare and subtract per step.
    assign num_ext  = DW'({num_mag, {mic_pkg::LIMB_W{1'b0}}});
    assign den_ext  = DW'(den_mag);
    assign den_sh32 = DW'({den_mag, {mic_pkg::LIMB_W{1'b0}}});
    assign den_sh33 = den_sh32 << 1;
    assign rem_ge   = rem_reg >= dsh_reg;
    assign rem_sub  = rem_reg - dsh_reg;
    assign round_up = (rem_reg << 1) >= den_ext;
    assign q_round  = {1'b0, q_reg} + (mic_pkg::QUOT_BITS + 1)'(round_up);
    assign big      = sat_reg | (|q_round[mic_pkg::QUOT_BITS:32]);

    // Step sequencing.
    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            DV_IDLE:  if (ctl.go) st_next = DV_RUN;
            DV_RUN:   if (cnt_reg == CNT_W'(mic_pkg::QUOT_BITS - 1)) st_next = DV_ROUND;
            DV_ROUND: st_next = DV_IDLE;
            default:  st_next = DV_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= DV_IDLE;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            st_reg   <= st_next;
            done_reg <= (st_reg == DV_ROUND);
            if (st_reg == DV_RUN)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            else
            begin
                cnt_reg <= '0;
            end
        end
    end

    // Remainder, shifted divisor and quotient bits.
    always_ff @(posedge clk)
    begin
        if (st_reg == DV_IDLE && ctl.go)
        begin
            rem_reg <= num_ext;
            dsh_reg <= den_sh32;
            sat_reg <= num_ext >= den_sh33;
            neg_reg <= ctl.neg;
            q_reg   <= '0;
        end
        else if (st_reg == DV_RUN)
        begin
            if (rem_ge)
            begin
                rem_reg <= rem_sub;
            end
            q_reg   <= {q_reg[mic_pkg::QUOT_BITS-2:0], rem_ge};
            dsh_reg <= dsh_reg >> 1;
        end
        else if (st_reg == DV_ROUND)
        begin
            quot_reg <= mic_pkg::sat_q32(big, q_round[31:0], neg_reg);
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

/* design/matrix_inverse_cofactor.sv */
// Matrix inverse by adjugate over determinant, Q16.16; uses mic_pkg and mic_divider.
// Loading takes one element per cycle; busy rises after the n*n-th element.
// The determinant comes first, then each inverse element in turn; run time is set by the
// permutation scan and the one 32x32 limb multiplier. Results cannot be stalled.
// Reset: order 4, load count zero, no result pending; the matrix store is not cleared.
`include "matrix_inverse_cofactor_assert.svh"
module matrix_inverse_cofactor #(
    parameter int MAX_ORDER = mic_pkg::MAX_ORDER_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [31:0]            element,
    input  logic                          cfg_write,
    input  logic [mic_pkg::ORDER_W-1:0]   cfg_data,
    output logic                          result_strobe,
    output logic signed [31:0]            inverse_value,
    output logic [3:0]                    position,
    output logic signed [31:0]            determinant,
    output logic                          singular,
    output logic                          last
);

    localparam int OW      = mic_pkg::ORDER_W;
    localparam int LW      = mic_pkg::LIMB_W;
    localparam int CELLS   = MAX_ORDER * MAX_ORDER;
    localparam int ADDR_W  = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int CNT_W   = $clog2(CELLS + 1);
    localparam int DIGIT_W = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
    localparam int KW      = $clog2(MAX_ORDER + 1);
    localparam int ACC_W   = LW * MAX_ORDER;
    localparam int SUM_W   = ACC_W + mic_pkg::SUM_GUARD;

    localparam logic [3:0] S_LOAD   = 4'd0;
    localparam logic [3:0] S_SCAN   = 4'd1;
    localparam logic [3:0] S_NEXTK  = 4'd2;
    localparam logic [3:0] S_MUL    = 4'd3;
    localparam logic [3:0] S_ADD    = 4'd4;
    localparam logic [3:0] S_STEP   = 4'd5;
    localparam logic [3:0] S_FINISH = 4'd6;
    localparam logic [3:0] S_DETQ   = 4'd7;
    localparam logic [3:0] S_DIVW   = 4'd8;

    // Control registers.
    logic [3:0]          state_reg, state_next;
    logic [OW-1:0]       order_reg;
    logic [CNT_W-1:0]    load_cnt_reg;
    logic [DIGIT_W-1:0]  dig_reg [MAX_ORDER];
    logic                det_mode_reg;
    logic [DIGIT_W-1:0]  x_reg, tgt_reg;
    logic [KW-1:0]       k_reg;
    logic [DIGIT_W-1:0]  limb_reg;
    logic                strobe_reg;

    // Datapath registers and the matrix store.
    logic [31:0]         mem [CELLS];
    logic [31:0]         rd_reg;
    logic [ACC_W-1:0]    acc_reg;
    logic [LW-1:0]       carry_reg;
    logic                neg_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic [SUM_W-1:0]    det_mag_reg;
    logic                det_neg_reg;
    logic [31:0]         detq_reg;
    logic [31:0]         inv_out_reg, det_out_reg;
    logic [3:0]          pos_out_reg;
    logic                sing_out_reg, last_out_reg;

    // Combinational signals.
    logic [OW-1:0]       n_act;
    logic [CNT_W-1:0]    total;
    logic [DIGIT_W-1:0]  n_m1_d;
    logic                perm_ok, parity, match_tgt, overflow;
    logic [DIGIT_W-1:0]  dig_k;
    logic [DIGIT_W-1:0]  dig_next [MAX_ORDER];
    logic                k_done, skip_k, limb_end, tuple_ok, at_last;
    logic                mem_we, mem_re;
    logic [ADDR_W-1:0]   rd_addr;
    logic [31:0]         emag;
    logic [63:0]         prod;
    logic [ACC_W-1:0]    acc_next;
    logic [SUM_W-1:0]    sum_next, sum_mag;
    logic                sum_neg, sum_zero;
    logic [SUM_W:0]      dq_tmp, dq_mag;
    logic [7:0]          pos_full;
    mic_pkg::div_ctl_t   div_ctl;
    logic                div_done;
    logic [31:0]         div_quot;

    // Active order: zero acts as one, above the maximum acts as the maximum.
    always_comb
    begin
        if (order_reg == '0)
        begin
            n_act = OW'(1);
        end
        else if (order_reg > OW'(MAX_ORDER))
        begin
            n_act = OW'(MAX_ORDER);
        end
        else
        begin
            n_act = order_reg;
        end
    end

    assign total  = CNT_W'(n_act) * CNT_W'(n_act);
    assign n_m1_d = DIGIT_W'(n_act - OW'(1));

    // Permutation test, sign, column select and odometer step over the digit row.
    always_comb
    begin
        logic carry;
        perm_ok   = 1'b1;
        parity    = 1'b0;
        match_tgt = 1'b0;
        dig_k     = '0;
        carry     = 1'b1;
        for (int i = 0; i < MAX_ORDER; i++)
        begin
            dig_next[i] = dig_reg[i];
            if (OW'(i) < n_act)
            begin
                for (int j = i + 1; j < MAX_ORDER; j++)
                begin
                    if (OW'(j) < n_act)
                    begin
                        if (dig_reg[i] == dig_reg[j]) perm_ok = 1'b0;
                        if (dig_reg[i] > dig_reg[j]) parity = ~parity;
                    end
                end
                if (DIGIT_W'(i) == x_reg && dig_reg[i] == tgt_reg) match_tgt = 1'b1;
                if (KW'(i) == k_reg) dig_k = dig_reg[i];
                if (carry)
                begin
                    if (dig_reg[i] == n_m1_d)
                    begin
                        dig_next[i] = '0;
                    end
                    else
                    begin
                        dig_next[i] = dig_reg[i] + DIGIT_W'(1);
                        carry = 1'b0;
                    end
                end
            end
        end
        overflow = carry;
    end

    assign tuple_ok = perm_ok && (det_mode_reg || match_tgt);
    assign k_done   = (k_reg == KW'(n_act));
    assign skip_k   = !det_mode_reg && (k_reg == KW'(x_reg));
    assign limb_end = (limb_reg == DIGIT_W'(MAX_ORDER - 1));
    assign at_last  = (tgt_reg == n_m1_d) && (x_reg == n_m1_d);

    // Store port control.
    assign mem_we  = (state_reg == S_LOAD) && start;
    assign mem_re  = (state_reg == S_NEXTK) && !k_done && !skip_k;
    assign rd_addr = ADDR_W'(k_reg) * ADDR_W'(n_act) + ADDR_W'(dig_k);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[load_cnt_reg[ADDR_W-1:0]] <= element;
        end
        if (mem_re)
        begin
            rd_reg <= mem[rd_addr];
        end
    end

    // One limb of the running product per cycle.
    assign emag     = rd_reg[31] ? (~rd_reg) + 32'd1 : rd_reg;
    assign prod     = 64'(acc_reg[LW-1:0]) * 64'(emag) + 64'(carry_reg);
    assign acc_next = ACC_W'({prod[LW-1:0], acc_reg} >> LW);

    // Term accumulation and sum magnitude.
    assign sum_next = neg_reg ? sum_reg - SUM_W'(acc_reg) : sum_reg + SUM_W'(acc_reg);
    assign sum_neg  = sum_reg[SUM_W-1];
    assign sum_zero = (sum_reg == '0);
    assign sum_mag  = sum_neg ? (~sum_reg) + SUM_W'(1) : sum_reg;

    // Determinant scaled back to Q16.16 with rounding.
    always_comb
    begin
        dq_tmp = '0;
        for (int i = 0; i < MAX_ORDER; i++)
        begin
            if (OW'(i) == n_act - OW'(1))
            begin
                dq_tmp = {det_mag_reg, 1'b0} >> (mic_pkg::FRAC_W * i);
            end
        end
        dq_mag = (dq_tmp >> 1) + (SUM_W + 1)'(dq_tmp[0]);
    end

    assign pos_full = 8'(tgt_reg) * 8'(n_act) + 8'(x_reg);

    // Divider for the inverse elements.
    assign div_ctl.go  = (state_reg == S_FINISH) && !det_mode_reg;
    assign div_ctl.neg = sum_neg ^ det_neg_reg;

    mic_divider #(
        .MAG_W (SUM_W)
    ) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (div_ctl),
        .num_mag (sum_mag),
        .den_mag (det_mag_reg),
        .done    (div_done),
        .quot    (div_quot)
    );

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_LOAD:   if (start && (load_cnt_reg + CNT_W'(1) == total)) state_next = S_SCAN;
            S_SCAN:   state_next = tuple_ok ? S_NEXTK : S_STEP;
            S_NEXTK:
            begin
                if (k_done) state_next = S_ADD;
                else if (!skip_k) state_next = S_MUL;
            end
            S_MUL:    if (limb_end) state_next = S_NEXTK;
            S_ADD:    state_next = S_STEP;
            S_STEP:   state_next = overflow ? S_FINISH : S_SCAN;
            S_FINISH:
            begin
                if (!det_mode_reg) state_next = S_DIVW;
                else if (sum_zero) state_next = S_LOAD;
                else state_next = S_DETQ;
            end
            S_DETQ:   state_next = S_SCAN;
            S_DIVW:   if (div_done) state_next = at_last ? S_LOAD : S_SCAN;
            default:  state_next = S_LOAD;
        endcase
    end

    // Control register updates.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_LOAD;
            order_reg    <= mic_pkg::ORDER_RESET;
            load_cnt_reg <= '0;
            det_mode_reg <= 1'b0;
            x_reg        <= '0;
            tgt_reg      <= '0;
            k_reg        <= '0;
            limb_reg     <= '0;
            strobe_reg   <= 1'b0;
            for (int i = 0; i < MAX_ORDER; i++)
            begin
                dig_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= ((state_reg == S_FINISH) && det_mode_reg && sum_zero)
                          || ((state_reg == S_DIVW) && div_done);
            if (mem_we)
            begin
                if (load_cnt_reg + CNT_W'(1) == total)
                begin
                    load_cnt_reg <= '0;
                    det_mode_reg <= 1'b1;
                    for (int i = 0; i < MAX_ORDER; i++)
                    begin
                        dig_reg[i] <= '0;
                    end
                end
                else
                begin
                    load_cnt_reg <= load_cnt_reg + CNT_W'(1);
                end
            end
            if (cfg_write)
            begin
                order_reg    <= cfg_data;
                load_cnt_reg <= '0;
            end
            if (state_reg == S_SCAN && tuple_ok)
            begin
                k_reg <= '0;
            end
            if (state_reg == S_NEXTK)
            begin
                limb_reg <= '0;
                if (!k_done && skip_k)
                begin
                    k_reg <= k_reg + KW'(1);
                end
            end
            if (state_reg == S_MUL)
            begin
                limb_reg <= limb_reg + DIGIT_W'(1);
                if (limb_end)
                begin
                    k_reg <= k_reg + KW'(1);
                end
            end
            if (state_reg == S_STEP)
            begin
                for (int i = 0; i < MAX_ORDER; i++)
                begin
                    dig_reg[i] <= dig_next[i];
                end
            end
            if (state_reg == S_DETQ)
            begin
                det_mode_reg <= 1'b0;
                x_reg        <= '0;
                tgt_reg      <= '0;
                for (int i = 0; i < MAX_ORDER; i++)
                begin
                    dig_reg[i] <= '0;
                end
            end
            if (state_reg == S_DIVW && div_done && !at_last)
            begin
                if (x_reg == n_m1_d)
                begin
                    x_reg   <= '0;
                    tgt_reg <= tgt_reg + DIGIT_W'(1);
                end
                else
                begin
                    x_reg <= x_reg + DIGIT_W'(1);
                end
                for (int i = 0; i < MAX_ORDER; i++)
                begin
                    dig_reg[i] <= '0;
                end
            end
        end
    end

    // Datapath register updates.
    always_ff @(posedge clk)
    begin
        if ((state_reg == S_LOAD && state_next == S_SCAN) || state_reg == S_DETQ
            || (state_reg == S_DIVW && div_done))
        begin
            sum_reg <= '0;
        end
        if (state_reg == S_SCAN && tuple_ok)
        begin
            acc_reg <= ACC_W'(1);
            neg_reg <= parity;
        end
        if (state_reg == S_NEXTK)
        begin
            carry_reg <= '0;
        end
        if (state_reg == S_MUL)
        begin
            acc_reg   <= acc_next;
            carry_reg <= prod[63:LW];
            if (limb_end)
            begin
                neg_reg <= neg_reg ^ rd_reg[31];
            end
        end
        if (state_reg == S_ADD)
        begin
            sum_reg <= sum_next;
        end
        if (state_reg == S_FINISH && det_mode_reg)
        begin
            det_mag_reg <= sum_mag;
            det_neg_reg <= sum_neg;
            if (sum_zero)
            begin
                inv_out_reg  <= '0;
                pos_out_reg  <= '0;
                det_out_reg  <= '0;
                sing_out_reg <= 1'b1;
                last_out_reg <= 1'b1;
            end
        end
        if (state_reg == S_DETQ)
        begin
            detq_reg <= mic_pkg::sat_q32(|dq_mag[SUM_W:32], dq_mag[31:0], det_neg_reg);
        end
        if (state_reg == S_DIVW && div_done)
        begin
            inv_out_reg  <= div_quot;
            pos_out_reg  <= pos_full[3:0];
            det_out_reg  <= detq_reg;
            sing_out_reg <= 1'b0;
            last_out_reg <= at_last;
        end
    end

    assign busy          = (state_reg != S_LOAD);
    assign result_strobe = strobe_reg;
    assign inverse_value = inv_out_reg;
    assign position      = pos_out_reg;
    assign determinant   = det_out_reg;
    assign singular      = sing_out_reg;
    assign last          = last_out_reg;

    // Checks on result sequencing and load bookkeeping.
    `MIC_ASSERT_IMPLY(a_mid_result_busy, result_strobe && !last, busy)
    `MIC_ASSERT_NEXT(a_strobe_single, result_strobe, !result_strobe)
    `MIC_ASSERT_IMPLY(a_singular_last, result_strobe && singular, last)
    `MIC_ASSERT_IMPLY(a_load_in_range, 1'b1, load_cnt_reg < total)

endmodule

/* dv/matrix_inverse_cofactor_checker.sv */
`timescale 1ns / 1ps
// Checker for the matrix inverse block: watches the configuration, element and result ports,
// predicts every inverse element in exact wide arithmetic and compares. Uses mic_pkg.
module matrix_inverse_cofactor_checker #(
    parameter int MAX_ORDER = 4
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic                        busy,
    input  logic signed [31:0]          element,
    input  logic                        cfg_write,
    input  logic [mic_pkg::ORDER_W-1:0] cfg_data,
    input  logic                        result_strobe,
    input  logic signed [31:0]          inverse_value,
    input  logic [3:0]                  position,
    input  logic signed [31:0]          determinant,
    input  logic                        singular,
    input  logic                        last,
    output int                          fail_count,
    output int                          pending_count
);
    localparam int CELLS = MAX_ORDER * MAX_ORDER;
    localparam int WW    = 192;

    typedef logic signed [WW-1:0] wide_t;

    typedef struct packed {
        logic [31:0] inv;
        logic [3:0]  pos;
        logic [31:0] det;
        logic        sing;
        logic        lst;
    } inv_entry_t;

    logic [mic_pkg::ORDER_W-1:0] order_reg;
    logic [31:0]                 cells [CELLS];
    int                          loaded;
    inv_entry_t                  expected_q [$];

    assign pending_count = expected_q.size();

    function automatic int active_order();
        if (order_reg == 0) return 1;
        if (order_reg > MAX_ORDER) return MAX_ORDER;
        return int'(order_reg);
    endfunction

    // Exact minor determinant over row and column masks, expanded along the lowest row.
    function automatic wide_t minor_det(input int rows, input int cols, input int n);
        wide_t sum;
        wide_t term;
        int    r;
        logic  odd;
        sum = '0;
        odd = 1'b0;
        if (rows == 0) return wide_t'(1);
        r = 0;
        while (r < n && !rows[r]) r++;
        for (int c = 0; c < n; c++)
        begin
            if (cols[c])
            begin
                term = minor_det(rows & ~(1 << r), cols & ~(1 << c), n)
                       * wide_t'($signed(cells[(r * n + c) % CELLS]));
                sum = odd ? sum - term : sum + term;
                odd = !odd;
            end
        end
        return sum;
    endfunction

    // Quotient rounded half away from zero, saturated to a signed 32-bit word.
    function automatic logic [31:0] quot_round_sat(input wide_t num, input wide_t den);
        logic            neg;
        logic [WW-1:0]   an;
        logic [WW-1:0]   ad;
        logic [WW-1:0]   q;
        logic [WW-1:0]   rm;
        neg = (num < 0) != (den < 0);
        an  = (num < 0) ? -num : num;
        ad  = (den < 0) ? -den : den;
        q   = an / ad;
        rm  = an % ad;
        if ((rm << 1) >= ad) q = q + 1;
        if (!neg) return (q > 'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
        return (q > 'h8000_0000) ? 32'h8000_0000 : (~q[31:0]) + 32'd1;
    endfunction

    // Expected results for a fully loaded matrix.
    task automatic predict_inverse();
        int          n;
        int          all;
        wide_t       det;
        wide_t       cof;
        logic [31:0] det_q;
        inv_entry_t  e;
        n   = active_order();
        all = (1 << n) - 1;
        det = minor_det(all, all, n);
        if (det == 0)
        begin
            e = '{inv: '0, pos: '0, det: '0, sing: 1'b1, lst: 1'b1};
            expected_q.push_back(e);
            return;
        end
        det_q = quot_round_sat(det, wide_t'(1) <<< (16 * (n - 1)));
        for (int r = 0; r < n; r++)
        begin
            for (int c = 0; c < n; c++)
            begin
                cof = minor_det(all & ~(1 << c), all & ~(1 << r), n);
                if ((r + c) % 2 == 1) cof = -cof;
                e.inv  = quot_round_sat(cof <<< 32, det);
                e.pos  = 4'((r * n + c) % 16);
                e.det  = det_q;
                e.sing = 1'b0;
                e.lst  = (r == n - 1 && c == n - 1);
                expected_q.push_back(e);
            end
        end
    endtask

    // Track configuration and loading, and compare every result transaction.
    always @(posedge clk or negedge rst_n)
    begin
        inv_entry_t e;
        if (!rst_n)
        begin
            order_reg  = mic_pkg::ORDER_RESET;
            loaded     = 0;
            fail_count = 0;
            expected_q.delete();
        end
        else
        begin
            if (cfg_write)
            begin
                order_reg = cfg_data;
                loaded    = 0;
            end
            if (start && !busy)
            begin
                cells[loaded % CELLS] = element;
                loaded++;
                if (loaded >= active_order() * active_order())
                begin
                    loaded = 0;
                    predict_inverse();
                end
            end
            if (result_strobe)
            begin
                if (expected_q.size() == 0)
                begin
                    $display("%0t: unexpected result inv=%h pos=%0d", $time,
                             inverse_value, position);
                    fail_count++;
                end
                else
                begin
                    e = expected_q.pop_front();
                    if (inverse_value !== e.inv || position !== e.pos
                        || determinant !== e.det || singular !== e.sing || last !== e.lst)
                    begin
                        $display("%0t: mismatch expected inv=%h pos=%0d det=%h sing=%b last=%b",
                                 $time, e.inv, e.pos, e.det, e.sing, e.lst);
                        $display("%0t:          actual inv=%h pos=%0d det=%h sing=%b last=%b",
                                 $time, inverse_value, position, determinant, singular, last);
                        fail_count++;
                    end
                end
            end
        end
    end

endmodule

/* dv/matrix_inverse_cofactor_tb.sv */
`timescale 1ns / 1ps
// Testbench top for the matrix inverse block: drives orders and matrices, gives the verdict.
// Depends on mic_pkg, matrix_inverse_cofactor and matrix_inverse_cofactor_checker.
module matrix_inverse_cofactor_tb;
    localparam int  TARGET_ITEMS = 410;
    localparam longint CYCLE_LIMIT = 4_000_000;

    logic                        clk;
    logic                        rst_n;
    logic                        start;
    logic                        busy;
    logic signed [31:0]          element;
    logic                        cfg_write;
    logic [mic_pkg::ORDER_W-1:0] cfg_data;
    logic                        result_strobe;
    logic signed [31:0]          inverse_value;
    logic [3:0]                  position;
    logic signed [31:0]          determinant;
    logic                        singular;
    logic                        last;
    int                          fail_count;
    int                          pending_count;
    longint                      cycles;
    int                          sent;
    int                          order_now;
    logic [31:0]                 mat [16];

    matrix_inverse_cofactor i_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .element(element),
        .cfg_write(cfg_write), .cfg_data(cfg_data), .result_strobe(result_strobe),
        .inverse_value(inverse_value), .position(position), .determinant(determinant),
        .singular(singular), .last(last)
    );

    matrix_inverse_cofactor_checker i_checker (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .element(element),
        .cfg_write(cfg_write), .cfg_data(cfg_data), .result_strobe(result_strobe),
        .inverse_value(inverse_value), .position(position), .determinant(determinant),
        .singular(singular), .last(last), .fail_count(fail_count),
        .pending_count(pending_count)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Watchdog on total run length.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Mostly back to back, sometimes short gaps, rarely long ones.
    function automatic int pick_gap();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 55) return 0;
        if (sel < 92) return $urandom_range(1, 4);
        return $urandom_range(20, 80);
    endfunction

    // One element transaction; start stays high across back-to-back elements.
    task automatic send_element(input logic [31:0] val);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            start = 1'b0;
            repeat (gap) @(negedge clk);
        end
        start   = 1'b1;
        element = val;
        do @(posedge clk); while (busy);
        @(negedge clk);
        sent++;
    endtask

    // Let every expected result arrive and the block settle.
    task automatic drain();
        start = 1'b0;
        while (pending_count != 0 || busy) @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic set_order(input int ord);
        drain();
        cfg_write = 1'b1;
        cfg_data  = 3'(ord);
        @(negedge clk);
        cfg_write = 1'b0;
        if (ord == 0) order_now = 1;
        else if (ord > 4) order_now = 4;
        else order_now = ord;
    endtask

    task automatic send_matrix();
        for (int i = 0; i < order_now * order_now; i++) send_element(mat[i]);
    endtask

    // Random matrix contents of several flavors.
    task automatic build_matrix(input int flavor);
        int n;
        n = order_now;
        for (int i = 0; i < 16; i++)
        begin
            case (flavor)
                0: mat[i] = 32'($signed($urandom_range(0, 32'h8_0000)) - 32'sh4_0000);
                1: mat[i] = $urandom;
                2: mat[i] = 32'($signed($urandom_range(0, 6)) - 3) <<< 16;
                3:
                begin
                    case ($urandom_range(0, 4))
                        0: mat[i] = 32'h8000_0000;
                        1: mat[i] = 32'h7FFF_FFFF;
                        2: mat[i] = 32'h0;
                        default: mat[i] = $urandom;
                    endcase
                end
                default: mat[i] = 32'($signed($urandom_range(0, 8)) - 4);
            endcase
        end
        // Flavor 2, half the time: last row repeats the first, singular above order one.
        if (flavor == 2 && $urandom_range(0, 1) == 1)
        begin
            for (int c = 0; c < n; c++) mat[(n - 1) * n + c] = mat[c];
        end
    endtask

    initial
    begin
        int ord;
        cycles    = 0;
        sent      = 0;
        order_now = 4;
        rst_n     = 1'b0;
        start     = 1'b0;
        element   = '0;
        cfg_write = 1'b0;
        cfg_data  = mic_pkg::ORDER_RESET;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: order 1 extremes, zero determinant, unit and minus one.
        set_order(1);
        send_element(32'h0);
        send_element(32'h0001_0000);
        send_element(32'hFFFF_0000);
        send_element(32'h7FFF_FFFF);
        send_element(32'h8000_0000);
        send_element(32'h1);
        // Order 0 acts as 1.
        set_order(0);
        send_element(32'h0002_0000);
        // Tiny determinant at order 2 and an identity.
        set_order(2);
        mat = '{0: 32'h1, 3: 32'h1, default: 32'h0};
        send_matrix();
        mat = '{0: 32'h1_0000, 3: 32'h1_0000, default: 32'h0};
        send_matrix();
        // Order above the maximum acts as the maximum; a singular matrix of ones.
        set_order(7);
        mat = '{default: 32'h1_0000};
        send_matrix();

        // Random phases through all order settings.
        while (sent < TARGET_ITEMS)
        begin
            ord = $urandom_range(0, 99);
            if (ord < 10) ord = $urandom_range(0, 1) ? 0 : $urandom_range(5, 7);
            else ord = $urandom_range(1, 4);
            set_order(ord);
            repeat ($urandom_range(1, 4))
            begin
                build_matrix($urandom_range(0, 4));
                send_matrix();
                // Occasionally hold off until all results are back.
                if ($urandom_range(0, 5) == 0) drain();
            end
            // Sometimes leave a partial load that the next order write discards.
            if (order_now > 1 && $urandom_range(0, 4) == 0)
            begin
                repeat ($urandom_range(1, order_now * order_now - 1)) send_element($urandom);
            end
        end

        drain();
        repeat (200) @(negedge clk);
        if (fail_count == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

/* files.f */
+incdir+design
design/mic_pkg.sv
design/mic_divider.sv
design/matrix_inverse_cofactor.sv
dv/matrix_inverse_cofactor_checker.sv
dv/matrix_inverse_cofactor_tb.sv
